### rtl/core/csi_parameter_parser_macros.svh
// Assertion helpers for the CSI parameter parser.
`ifndef CSI_PARAMETER_PARSER_MACROS_SVH
`define CSI_PARAMETER_PARSER_MACROS_SVH

// Checked only while out of reset.
`define CSI_PP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define CSI_PP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/core/csi_pp_pkg.sv
package csi_pp_pkg;

    typedef struct packed {
        logic               kind;
        logic [3:0]         arg_index;
        logic signed [31:0] arg_value;
        logic               private_flag;
        logic [7:0]         final_char;
        logic [7:0]         intermediate_char;
        logic [4:0]         arg_count;
        logic               last;
    } result_t;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic KIND_ARG     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Output queue holds a few results so the input side keeps moving.
    localparam int OUTQ_DEPTH = 4;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic signed [31:0] arg_val(input logic ovf, input logic neg,
                                                   input logic [30:0] mag);
        logic [31:0] m;
        m = {1'b0, mag};
        if (ovf) begin
            return -32'sd1;
        end else if (neg) begin
            return $signed(32'd0 - m);
        end
        return $signed(m);
    endfunction

endpackage

### rtl/core/csi_parameter_parser.sv
// CSI parameter parser: takes the body of a CSI escape one byte per beat and
// returns each parsed argument as a result beat, plus a summary beat (last = 1)
// on the beat that ends the buffer. One input beat is accepted per cycle; each
// beat is parsed from the input register once the output queue has room, and its
// zero, one or two results go into a four-entry output queue. Results leave one
// per cycle while the sink is ready, from the head of the queue; the input side
// only stalls when the queue has fewer than two free places, which happens when
// the sink is slow or when beats yielding two results come in a row.
module csi_parameter_parser #(
    parameter int MAX_ARGS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_has_byte,
    input  logic               s_end_of_buffer,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [3:0]         m_arg_index,
    output logic signed [31:0] m_arg_value,
    output logic               m_private_flag,
    output logic [7:0]         m_final_char,
    output logic [7:0]         m_intermediate_char,
    output logic [4:0]         m_arg_count,
    output logic               m_last
);
    import csi_pp_pkg::*;

`include "csi_parameter_parser_macros.svh"

    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       has_reg;
    logic       eob_reg;
    logic       advance;
    logic       room_two;
    logic       pop;
    logic [1:0] res_count;
    logic [1:0] push_n;
    result_t    res0, res1, head;

    assign advance       = in_valid_reg && room_two;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign push_n        = advance ? res_count : 2'd0;
    assign pop           = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_data_byte;
            has_reg  <= s_has_byte;
            eob_reg  <= s_end_of_buffer;
        end
    end

    csi_pp_core #(
        .MAX_ARGS(MAX_ARGS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .data_byte     (byte_reg),
        .has_byte      (has_reg),
        .end_of_buffer (eob_reg),
        .res0          (res0),
        .res1          (res1),
        .res_count     (res_count)
    );

    csi_pp_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push0     (res0),
        .push1     (res1),
        .pop       (pop),
        .room_two  (room_two),
        .not_empty (m_valid),
        .head      (head)
    );

    assign m_kind              = head.kind;
    assign m_arg_index         = head.arg_index;
    assign m_arg_value         = head.arg_value;
    assign m_private_flag      = head.private_flag;
    assign m_final_char        = head.final_char;
    assign m_intermediate_char = head.intermediate_char;
    assign m_arg_count         = head.arg_count;
    assign m_last              = head.last;

    // accepted beat lands in the input register
    `CSI_PP_ASSERT(a_capture, s_valid && s_ready |=> in_valid_reg, "accepted beat not captured")
    // a stalled beat stays put until the queue has room
    `CSI_PP_ASSERT(a_hold, in_valid_reg && !advance |=> in_valid_reg && $stable(byte_reg) && $stable(eob_reg), "stalled beat lost")
    // summary beats and only summary beats close a run
    `CSI_PP_ASSERT_ALWAYS(a_last_kind, m_valid |-> (m_last == m_kind), "last flag disagrees with kind")

endmodule

### rtl/core/csi_pp_core.sv
module csi_pp_core #(
    parameter int MAX_ARGS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [7:0]          data_byte,
    input  logic                has_byte,
    input  logic                end_of_buffer,
    output csi_pp_pkg::result_t res0,
    output csi_pp_pkg::result_t res1,
    output logic [1:0]          res_count
);
    import csi_pp_pkg::*;

    localparam int CW = $clog2(MAX_ARGS + 1);
    localparam logic [CW-1:0] ArgLimit = CW'(MAX_ARGS);

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_WS     = 3'd1;
    localparam logic [2:0] PH_SIGN   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_NEXT   = 3'd4;
    localparam logic [2:0] PH_IDLE   = 3'd5;

    logic [2:0]    phase_reg, phase_next;
    logic          private_reg, private_next;
    logic          colon_reg, colon_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [30:0]   mag_reg, mag_next;
    logic          ovf_reg, ovf_next;
    logic          neg_reg, neg_next;
    logic [7:0]    tfirst_reg, tfirst_next;
    logic [7:0]    tsecond_reg, tsecond_next;
    logic [1:0]    tseen_reg, tseen_next;
    logic [7:0]    stop_reg, stop_next;
    logic [7:0]    nchar_reg, nchar_next;

    // state after the byte of this beat
    logic [2:0]    ph_m, ph_eff;
    logic          prv_m, col_m, ovf_m, neg_m;
    logic [CW-1:0] cnt_m;
    logic [30:0]   mag_m;
    logic [7:0]    tf_m, ts_m, stop_m, nc_m;
    logic [1:0]    tn_m;
    logic          take, do_after, byte_emit;
    logic signed [31:0] b_val;
    logic [34:0]   prod;
    logic [7:0]    sep;

    // end-of-buffer handling
    logic          eob_emit;
    logic signed [31:0] e_val;
    logic [CW-1:0] cnt_f;
    logic [7:0]    stop_f, nc_f;
    logic [CW+4:0] cnt_f_ext;

    result_t b_res, e_res, s_res;

    function automatic result_t mk_arg(input logic [CW-1:0] cnt_in,
                                       input logic signed [31:0] v, input logic prv);
        logic [CW+4:0] pre;
        logic [CW+4:0] post;
        result_t r;
        pre                 = {5'd0, cnt_in};
        post                = pre + 1'b1;
        r.kind              = KIND_ARG;
        r.arg_index         = pre[3:0];
        r.arg_value         = v;
        r.private_flag      = prv;
        r.final_char        = 8'd0;
        r.intermediate_char = 8'd0;
        r.arg_count         = post[4:0];
        r.last              = 1'b0;
        return r;
    endfunction

    assign prod = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0} + {31'd0, data_byte[3:0]};

    always_comb begin
        ph_m      = phase_reg;
        prv_m     = private_reg;
        col_m     = colon_reg;
        cnt_m     = cnt_reg;
        mag_m     = mag_reg;
        ovf_m     = ovf_reg;
        neg_m     = neg_reg;
        tf_m      = tfirst_reg;
        ts_m      = tsecond_reg;
        tn_m      = tseen_reg;
        stop_m    = stop_reg;
        nc_m      = nchar_reg;
        take      = has_byte;
        do_after  = 1'b0;
        byte_emit = 1'b0;
        b_val     = 32'sd0;
        sep       = CH_SEMI;
        ph_eff    = (phase_reg == PH_START) ? PH_WS : phase_reg;

        // token state is already clear at the start of a sequence
        if (has_byte && phase_reg == PH_START) begin
            ph_m = PH_WS;
            if (data_byte == CH_QMARK) begin
                prv_m = 1'b1;
                take  = 1'b0;
            end
        end

        if (take) begin
            case (ph_eff)
                PH_WS, PH_SIGN: begin
                    if (is_digit(data_byte)) begin
                        ph_m  = PH_DIGITS;
                        mag_m = {27'd0, data_byte[3:0]};
                    end else if (ph_eff == PH_WS && (is_space(data_byte) ||
                                 data_byte == CH_PLUS || data_byte == CH_MINUS)) begin
                        if (tseen_reg == 2'd0) begin
                            tf_m = data_byte;
                        end else if (tseen_reg == 2'd1) begin
                            ts_m = data_byte;
                        end
                        if (tseen_reg < 2'd2) begin
                            tn_m = tseen_reg + 2'd1;
                        end
                        if (data_byte == CH_MINUS) begin
                            neg_m = 1'b1;
                        end
                        if (!is_space(data_byte)) begin
                            ph_m = PH_SIGN;
                        end
                    end else begin
                        byte_emit = 1'b1;
                        cnt_m     = cnt_reg + 1'b1;
                        if (tseen_reg == 2'd0) begin
                            do_after = 1'b1;
                        end else begin
                            stop_m = tfirst_reg;
                            nc_m   = (tseen_reg >= 2'd2) ? tsecond_reg : data_byte;
                            ph_m   = PH_IDLE;
                        end
                    end
                end
                PH_DIGITS: begin
                    if (is_digit(data_byte)) begin
                        if (!ovf_reg) begin
                            if (prod[34:31] != 4'd0) begin
                                ovf_m = 1'b1;
                            end else begin
                                mag_m = prod[30:0];
                            end
                        end
                    end else begin
                        byte_emit = 1'b1;
                        b_val     = arg_val(ovf_reg, neg_reg, mag_reg);
                        cnt_m     = cnt_reg + 1'b1;
                        do_after  = 1'b1;
                    end
                end
                PH_NEXT: begin
                    nc_m = data_byte;
                    ph_m = PH_IDLE;
                end
                default: begin
                end
            endcase
        end

        if (do_after) begin
            col_m = colon_reg | (data_byte == CH_COLON);
            sep   = col_m ? CH_COLON : CH_SEMI;
            if (data_byte != sep || cnt_m >= ArgLimit) begin
                stop_m = data_byte;
                ph_m   = PH_NEXT;
            end else begin
                ph_m  = PH_WS;
                mag_m = 31'd0;
                ovf_m = 1'b0;
                neg_m = 1'b0;
                tn_m  = 2'd0;
                tf_m  = 8'd0;
                ts_m  = 8'd0;
            end
        end
    end

    always_comb begin
        eob_emit = 1'b0;
        e_val    = 32'sd0;
        cnt_f    = cnt_m;
        stop_f   = stop_m;
        nc_f     = nc_m;
        case (ph_m)
            PH_WS, PH_SIGN: begin
                if (tn_m != 2'd0) begin
                    eob_emit = 1'b1;
                    cnt_f    = cnt_m + 1'b1;
                    stop_f   = tf_m;
                    nc_f     = (tn_m >= 2'd2) ? ts_m : 8'd0;
                end else begin
                    stop_f = 8'd0;
                    nc_f   = 8'd0;
                end
            end
            PH_DIGITS: begin
                eob_emit = 1'b1;
                e_val    = arg_val(ovf_m, neg_m, mag_m);
                cnt_f    = cnt_m + 1'b1;
                stop_f   = 8'd0;
                nc_f     = 8'd0;
            end
            PH_NEXT: begin
                nc_f = 8'd0;
            end
            PH_IDLE: begin
            end
            default: begin
                stop_f = 8'd0;
                nc_f   = 8'd0;
            end
        endcase
    end

    assign cnt_f_ext = {5'd0, cnt_f};

    always_comb begin
        b_res = mk_arg(cnt_reg, b_val, prv_m);
        e_res = mk_arg(cnt_m, e_val, prv_m);
        s_res.kind              = KIND_SUMMARY;
        s_res.arg_index         = 4'd0;
        s_res.arg_value         = 32'sd0;
        s_res.private_flag      = prv_m;
        s_res.final_char        = stop_f;
        s_res.intermediate_char = nc_f;
        s_res.arg_count         = cnt_f_ext[4:0];
        s_res.last              = 1'b1;

        // at most two results: a byte and an end-of-buffer argument never coincide
        res0 = s_res;
        res1 = s_res;
        if (byte_emit) begin
            res0 = b_res;
            res1 = eob_emit ? e_res : s_res;
        end else if (eob_emit) begin
            res0 = e_res;
        end
        if (end_of_buffer) begin
            res_count = (byte_emit || eob_emit) ? 2'd2 : 2'd1;
        end else begin
            res_count = byte_emit ? 2'd1 : 2'd0;
        end
    end

    always_comb begin
        if (end_of_buffer) begin
            phase_next   = PH_START;
            private_next = 1'b0;
            colon_next   = 1'b0;
            cnt_next     = '0;
            mag_next     = 31'd0;
            ovf_next     = 1'b0;
            neg_next     = 1'b0;
            tfirst_next  = 8'd0;
            tsecond_next = 8'd0;
            tseen_next   = 2'd0;
            stop_next    = 8'd0;
            nchar_next   = 8'd0;
        end else begin
            phase_next   = ph_m;
            private_next = prv_m;
            colon_next   = col_m;
            cnt_next     = cnt_m;
            mag_next     = mag_m;
            ovf_next     = ovf_m;
            neg_next     = neg_m;
            tfirst_next  = tf_m;
            tsecond_next = ts_m;
            tseen_next   = tn_m;
            stop_next    = stop_m;
            nchar_next   = nc_m;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            private_reg <= 1'b0;
            colon_reg   <= 1'b0;
            cnt_reg     <= '0;
            mag_reg     <= 31'd0;
            ovf_reg     <= 1'b0;
            neg_reg     <= 1'b0;
            tfirst_reg  <= 8'd0;
            tsecond_reg <= 8'd0;
            tseen_reg   <= 2'd0;
            stop_reg    <= 8'd0;
            nchar_reg   <= 8'd0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            private_reg <= private_next;
            colon_reg   <= colon_next;
            cnt_reg     <= cnt_next;
            mag_reg     <= mag_next;
            ovf_reg     <= ovf_next;
            neg_reg     <= neg_next;
            tfirst_reg  <= tfirst_next;
            tsecond_reg <= tsecond_next;
            tseen_reg   <= tseen_next;
            stop_reg    <= stop_next;
            nchar_reg   <= nchar_next;
        end
    end

endmodule

### rtl/core/csi_pp_outq.sv
module csi_pp_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          push_n,
    input  csi_pp_pkg::result_t push0,
    input  csi_pp_pkg::result_t push1,
    input  logic                pop,
    output logic                room_two,
    output logic                not_empty,
    output csi_pp_pkg::result_t head
);
    import csi_pp_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);
    localparam int CNTW = $clog2(OUTQ_DEPTH + 1);

    result_t         mem [OUTQ_DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [PW-1:0]   wr_plus1;

    assign wr_plus1   = wr_reg + 1'b1;
    assign wr_next    = wr_reg + PW'(push_n);
    assign rd_next    = rd_reg + PW'(pop);
    assign count_next = count_reg + CNTW'(push_n) - CNTW'(pop);
    assign room_two   = count_reg <= CNTW'(OUTQ_DEPTH - 2);
    assign not_empty  = count_reg != '0;
    assign head       = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[wr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem[wr_plus1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule
